// ===== rtl/sac_pkg.sv =====
// Shared types and constants for the stepper axis controller.
// Used by sac_next_state and stepper_axis_controller_core; no dependencies.
`timescale 1ns / 1ps

package sac_pkg;

  // Width of the internal position counter.
  localparam int POS_BITS = 16;

  // Reset values of the configuration registers.
  localparam logic [7:0]  HALF_PERIOD_RST = 8'd2;
  localparam logic [15:0] TRAVEL_MAX_RST  = 16'd1000;
  localparam logic [7:0]  SOFT_MARGIN_RST = 8'd50;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_HALF_PERIOD = 2'd0,
    REG_TRAVEL_MAX  = 2'd1,
    REG_SOFT_MARGIN = 2'd2,
    REG_INVERT_DIR  = 2'd3
  } sac_reg_t;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_HOME  = 2'd1,
    OP_MOVE  = 2'd2,
    OP_SPARE = 2'd3
  } sac_op_t;

  // Motion modes.
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_HOMING = 2'd1,
    MODE_MOVING = 2'd2
  } sac_mode_t;

  // Stop reasons.
  typedef enum logic [1:0] {
    WHY_NONE   = 2'd0,
    WHY_COUNT  = 2'd1,
    WHY_SWITCH = 2'd2,
    WHY_SOFT   = 2'd3
  } sac_why_t;

  // Configuration register set.
  typedef struct packed {
    logic [7:0]  half_period_ticks;
    logic [15:0] travel_max;
    logic [7:0]  soft_margin;
    logic        invert_direction;
  } sac_cfg_t;

  // Controller state.
  typedef struct packed {
    sac_mode_t           mode;
    logic                pulse_low_phase;
    logic [7:0]          tick_count;
    logic [15:0]         steps_done;
    logic [15:0]         steps_target;
    logic                moving_home;
    logic [POS_BITS-1:0] axis_position;
    logic                step_line;
    logic                dir_line;
    sac_why_t            last_reason;
  } sac_state_t;

  // One result item.
  typedef struct packed {
    logic        step_level;
    logic        dir_level;
    logic        drive_enabled;
    logic        busy_res;
    logic [15:0] position;
    logic [1:0]  stop_reason;
  } sac_result_t;

endpackage

// ===== rtl/stepper_axis_controller_core.sv =====
// Top level of the single-axis stepper controller with homing.
// Depends on sac_pkg and sac_next_state.
`timescale 1ns / 1ps

// Usage:
// Requests arrive on the in_ channel (valid/stall): a time tick, a homing
// command or a move command, each carrying a home switch sample. Every
// accepted request yields exactly one result on the out_ channel with the
// step, direction and enable levels, busy flag, position and stop reason
// as they stand after that request.
// A request accepted at an edge shows its result on the out_ ports right
// after that edge unless an earlier result still waits there. One request
// is taken per cycle while in_stall is low; the state update is one pass of
// compare and increment logic between the state registers.
// The result side has an output register backed by a skid register, so a
// request is still taken while one result waits. in_stall rises only when
// both hold results, and drops as soon as the receiver takes one.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the
// next edge; the user must make them only while idle (not enforced here).
// Synchronous reset (rst_n low) returns the registers to their defaults,
// clears the motion state and empties the output stages.

module stepper_axis_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_step_count,
  input  logic        in_toward_home,
  input  logic        in_home_switch,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_step_level,
  output logic        out_dir_level,
  output logic        out_drive_enabled,
  output logic        out_busy_res,
  output logic [15:0] out_position,
  output logic [1:0]  out_stop_reason
);
  import sac_pkg::*;

  sac_cfg_t    cfg_r;
  sac_state_t  state_r;
  sac_state_t  state_nxt;
  sac_result_t res_nxt;
  sac_result_t out_r;
  sac_result_t skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  logic        in_take;
  logic        out_take;
  logic        busy_nxt;

  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= HALF_PERIOD_RST;
      cfg_r.travel_max        <= TRAVEL_MAX_RST;
      cfg_r.soft_margin       <= SOFT_MARGIN_RST;
      cfg_r.invert_direction  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (sac_reg_t'(cfg_index))
        REG_HALF_PERIOD: cfg_r.half_period_ticks <= cfg_data[7:0];
        REG_TRAVEL_MAX:  cfg_r.travel_max        <= cfg_data;
        REG_SOFT_MARGIN: cfg_r.soft_margin       <= cfg_data[7:0];
        REG_INVERT_DIR:  cfg_r.invert_direction  <= cfg_data[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Next state for the request on the input ports.
  sac_next_state u_next (
    .st          (state_r),
    .cfg         (cfg_r),
    .op          (in_operation),
    .step_count  (in_step_count),
    .toward_home (in_toward_home),
    .home_switch (in_home_switch),
    .nxt         (state_nxt)
  );

  // Result fields as seen after the update.
  always_comb begin
    busy_nxt              = (state_nxt.mode == MODE_HOMING) ||
                            (state_nxt.mode == MODE_MOVING);
    res_nxt.step_level    = state_nxt.step_line;
    res_nxt.dir_level     = state_nxt.dir_line;
    res_nxt.drive_enabled = busy_nxt;
    res_nxt.busy_res      = busy_nxt;
    res_nxt.position      = 16'(state_nxt.axis_position);
    res_nxt.stop_reason   = state_nxt.last_reason;
  end

  // Controller state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode            <= MODE_IDLE;
      state_r.pulse_low_phase <= 1'b0;
      state_r.tick_count      <= 8'd0;
      state_r.steps_done      <= 16'd0;
      state_r.steps_target    <= 16'd0;
      state_r.moving_home     <= 1'b0;
      state_r.axis_position   <= '0;
      state_r.step_line       <= 1'b0;
      state_r.dir_line        <= 1'b0;
      state_r.last_reason     <= WHY_NONE;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // Output register and skid register valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r) begin
        out_valid_r <= in_take;
      end else if (out_take) begin
        out_valid_r  <= skid_valid_r || in_take;
        skid_valid_r <= 1'b0;
      end else if (in_take) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_r <= skid_valid_r ? skid_r : res_nxt;
    end
    if (out_valid_r && !out_take && in_take) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_step_level    = out_r.step_level;
  assign out_dir_level     = out_r.dir_level;
  assign out_drive_enabled = out_r.drive_enabled;
  assign out_busy_res      = out_r.busy_res;
  assign out_position      = out_r.position;
  assign out_stop_reason   = out_r.stop_reason;

endmodule

// ===== rtl/sac_next_state.sv =====
// Next-state logic of the stepper axis controller for one request.
// Depends on sac_pkg for the state, configuration and code types.
`timescale 1ns / 1ps

module sac_next_state (
  input  sac_pkg::sac_state_t st,
  input  sac_pkg::sac_cfg_t   cfg,
  input  logic [1:0]          op,
  input  logic [15:0]         step_count,
  input  logic                toward_home,
  input  logic                home_switch,
  output sac_pkg::sac_state_t nxt
);
  import sac_pkg::*;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  logic [15:0] soft_limit;
  logic [7:0]  half_period;
  logic [7:0]  tick_inc;
  logic [15:0] steps_inc;
  logic        pos_nonzero;
  logic        pos_below_max;
  logic        pos_at_limit;

  // Shared compares; position is widened so counter widths up to 32 bits compare cleanly.
  always_comb begin
    soft_limit    = (cfg.travel_max > 16'(cfg.soft_margin)) ?
                    (cfg.travel_max - 16'(cfg.soft_margin)) : 16'd0;
    half_period   = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
    tick_inc      = st.tick_count + 8'd1;
    steps_inc     = st.steps_done + 16'd1;
    pos_nonzero   = (st.axis_position != '0);
    pos_below_max = (32'(st.axis_position) < 32'(cfg.travel_max));
    pos_at_limit  = (32'(st.axis_position) >= 32'(soft_limit));
  end

  // State update for tick, homing and move requests.
  always_comb begin
    nxt = st;
    case (sac_op_t'(op))
      OP_TICK: begin
        if (st.mode == MODE_HOMING || st.mode == MODE_MOVING) begin
          if ((st.mode == MODE_HOMING || st.moving_home) && !home_switch) begin
            // Switch closed while running toward home.
            nxt.axis_position   = '0;
            nxt.mode            = MODE_IDLE;
            nxt.step_line       = 1'b0;
            nxt.pulse_low_phase = 1'b0;
            nxt.tick_count      = 8'd0;
            nxt.last_reason     = WHY_SWITCH;
          end else if (st.mode == MODE_MOVING && !st.moving_home && pos_at_limit) begin
            // Outward move reached the soft limit.
            nxt.mode            = MODE_IDLE;
            nxt.step_line       = 1'b0;
            nxt.pulse_low_phase = 1'b0;
            nxt.tick_count      = 8'd0;
            nxt.last_reason     = WHY_SOFT;
          end else if (tick_inc < half_period) begin
            nxt.tick_count = tick_inc;
          end else begin
            nxt.tick_count = 8'd0;
            if (!st.pulse_low_phase) begin
              // Falling edge of the step line: count the step in a move.
              nxt.step_line       = 1'b0;
              nxt.pulse_low_phase = 1'b1;
              if (st.mode == MODE_MOVING) begin
                if (st.moving_home) begin
                  if (pos_nonzero) nxt.axis_position = st.axis_position - POS_BITS'(1);
                end else if (st.axis_position != POS_MAX) begin
                  nxt.axis_position = st.axis_position + POS_BITS'(1);
                end
                nxt.steps_done = steps_inc;
                if (steps_inc >= st.steps_target) begin
                  nxt.mode            = MODE_IDLE;
                  nxt.step_line       = 1'b0;
                  nxt.pulse_low_phase = 1'b0;
                  nxt.last_reason     = WHY_COUNT;
                end
              end
            end else begin
              nxt.step_line       = 1'b1;
              nxt.pulse_low_phase = 1'b0;
            end
          end
        end else begin
          nxt.mode = MODE_IDLE;
        end
      end
      OP_HOME: begin
        if (home_switch) nxt.dir_line = ~cfg.invert_direction;
        nxt.moving_home     = 1'b1;
        nxt.step_line       = 1'b0;
        nxt.pulse_low_phase = 1'b0;
        nxt.tick_count      = 8'd0;
        if (!home_switch) begin
          // Already at home.
          nxt.axis_position = '0;
          nxt.mode          = MODE_IDLE;
          nxt.last_reason   = WHY_SWITCH;
        end else begin
          nxt.mode        = MODE_HOMING;
          nxt.step_line   = 1'b1;
          nxt.steps_done  = 16'd0;
          nxt.last_reason = WHY_NONE;
        end
      end
      OP_MOVE: begin
        // Direction changes only when the position bound allows the move.
        if (toward_home && pos_nonzero) nxt.dir_line = ~cfg.invert_direction;
        else if (!toward_home && pos_below_max) nxt.dir_line = cfg.invert_direction;
        nxt.moving_home     = toward_home;
        nxt.steps_target    = step_count;
        nxt.step_line       = 1'b0;
        nxt.pulse_low_phase = 1'b0;
        nxt.tick_count      = 8'd0;
        nxt.mode            = MODE_IDLE;
        if (toward_home && !home_switch) begin
          nxt.axis_position = '0;
          nxt.last_reason   = WHY_SWITCH;
        end else if (!toward_home && pos_at_limit) begin
          nxt.last_reason = WHY_SOFT;
        end else if (step_count == 16'd0) begin
          nxt.last_reason = WHY_COUNT;
        end else begin
          nxt.mode        = MODE_MOVING;
          nxt.step_line   = 1'b1;
          nxt.steps_done  = 16'd0;
          nxt.last_reason = WHY_NONE;
        end
      end
      default: begin
        nxt = st;
      end
    endcase
  end

endmodule
